@@ design/dhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// Datagram header validator package
// Shared types, verdict codes, register indexes and header constants.
// ----------------------------------------------------------------------------
package dhsv_pkg;

    // Position counter width; it saturates at its all-ones value.
    localparam int POS_W = 11;

    // Header layout.
    localparam int HDR_BYTES = 14;
    localparam int SEG_BYTES = 24;
    localparam int MIN_BYTES = HDR_BYTES + SEG_BYTES;

    // Field widths.
    localparam int SESSION_W  = 64;
    localparam int GCOUNT_W   = 4;
    localparam int GROUP_W    = 16;
    localparam int FIELD_W    = 5;
    localparam int LEN_W      = 32;
    localparam int PAYLOAD_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Segment command range; only a data command may carry a length.
    localparam logic [7:0] CMD_MIN  = 8'd81;
    localparam logic [7:0] CMD_MAX  = 8'd84;
    localparam logic [7:0] CMD_DATA = 8'd81;

    // Last byte index of a segment header.
    localparam logic [FIELD_W-1:0] SEG_LAST = FIELD_W'(SEG_BYTES - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SESSION     = 1'b0,
        REG_GROUP_COUNT = 1'b1
    } cfg_reg_t;

    // Verdict codes; zero means no fault.
    typedef enum logic [3:0] {
        V_OK      = 4'd0,
        V_PEER    = 4'd1,
        V_SIZE    = 4'd2,
        V_MAGIC   = 4'd3,
        V_SESSION = 4'd4,
        V_GROUP   = 4'd5,
        V_CONV    = 4'd6,
        V_CMD     = 4'd7,
        V_FRAG    = 4'd8,
        V_LENGTH  = 4'd9
    } verdict_t;

    // Status from the segment walker for the current byte.
    typedef struct packed {
        verdict_t fault;  // fault noted on this byte, V_OK for none
        logic     busy;   // a segment header or its data is still open
    } walk_status_t;

    // Expected magic byte at header offsets zero to three.
    function automatic logic [7:0] magic_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = 8'h44;  // 'D'
            2'd1:    b = 8'h55;  // 'U'
            2'd2:    b = 8'h52;  // 'R'
            2'd3:    b = 8'h31;  // '1'
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ design/dhsv_ifs.sv @@
// ----------------------------------------------------------------------------
// Datagram header validator channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Byte input channel.
interface dhsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       peer_usable;

    modport source (output valid, output data_byte, output last_byte,
                    output peer_usable, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input peer_usable, output ready);
endinterface

// Result output channel.
interface dhsv_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  verdict;
    logic [2:0]  group_index;
    logic [10:0] payload_bytes;

    modport source (output valid, output accepted, output verdict,
                    output group_index, output payload_bytes, input ready);
    modport sink   (input valid, input accepted, input verdict,
                    input group_index, input payload_bytes, output ready);
endinterface

// Configuration write channel.
interface dhsv_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  reg_index;
    logic [63:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ design/dhsv_seg_walk.sv @@
// ----------------------------------------------------------------------------
// Datagram header validator segment walker
// Tracks the 24-byte segment headers and their data after the main header.
// ----------------------------------------------------------------------------
module dhsv_seg_walk
    import dhsv_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1400
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,      // a byte is processed this cycle
    input  logic             walk,      // the byte lies past the main header
    input  logic             clear,     // the byte ends the datagram
    input  logic [7:0]       data_byte,
    input  logic [POS_W-1:0] position,
    output walk_status_t     status
);

    localparam logic [POS_W:0] MAX_W = (POS_W+1)'(MAX_DATAGRAM);

    logic [FIELD_W-1:0] field_reg,   field_next;
    logic [7:0]         cmd_reg,     cmd_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [POS_W-1:0]   left_reg,    left_next;
    verdict_t           pend_reg,    pend_next;

    logic [POS_W:0]     used;
    logic [POS_W:0]     room;
    verdict_t           fault;

    // Room left in the largest datagram after this byte.
    assign used = {1'b0, position} + (POS_W+1)'(1);
    assign room = (used < MAX_W) ? (MAX_W - used) : '0;

    // Next segment state for this byte.
    always_comb
    begin
        field_next = field_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        fault      = V_OK;
        if (walk) begin
            if (left_reg != '0) begin
                // Segment data byte.
                left_next = left_reg - POS_W'(1);
            end
            else begin
                // Field checks within the segment header.
                if (field_reg < FIELD_W'(4)) begin
                    if (data_byte != 8'h00 && pend_reg == V_OK)
                        pend_next = V_CONV;
                end
                else if (field_reg == FIELD_W'(4)) begin
                    cmd_next = data_byte;
                    if ((data_byte < CMD_MIN || data_byte > CMD_MAX) && pend_reg == V_OK)
                        pend_next = V_CMD;
                end
                else if (field_reg == FIELD_W'(5)) begin
                    if (data_byte != 8'h00 && (pend_reg == V_OK || pend_reg == V_CMD))
                        pend_next = V_FRAG;
                end
                else if (field_reg >= FIELD_W'(20)) begin
                    // Little-endian length; the first length byte clears the rest.
                    case (field_reg[1:0])
                        2'd0:    len_next = {24'h000000, data_byte};
                        2'd1:    len_next[15:8]  = data_byte;
                        2'd2:    len_next[23:16] = data_byte;
                        2'd3:    len_next[31:24] = data_byte;
                        default: len_next = len_reg;
                    endcase
                end

                // Header complete: report a held fault or check the length.
                if (field_reg != SEG_LAST) begin
                    field_next = field_reg + FIELD_W'(1);
                end
                else begin
                    field_next = '0;
                    if (pend_next != V_OK) begin
                        fault     = pend_next;
                        pend_next = V_OK;
                    end
                    else if (len_next > LEN_W'(room)) begin
                        fault = V_LENGTH;
                    end
                    else if (cmd_next != CMD_DATA && len_next != '0) begin
                        fault = V_LENGTH;
                    end
                    else begin
                        left_next = len_next[POS_W-1:0];
                    end
                end
            end
        end
    end

    assign status.fault = fault;
    assign status.busy  = (field_next != '0) || (left_next != '0);

    // Segment state registers, cleared at the end of each datagram.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_reg <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            pend_reg  <= V_OK;
        end
        else if (step) begin
            if (clear) begin
                field_reg <= '0;
                cmd_reg   <= '0;
                len_reg   <= '0;
                left_reg  <= '0;
                pend_reg  <= V_OK;
            end
            else begin
                field_reg <= field_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
                left_reg  <= left_next;
                pend_reg  <= pend_next;
            end
        end
    end

endmodule

@@ design/datagram_header_segment_validator.sv @@
// ----------------------------------------------------------------------------
// Datagram header and segment validator
// Checks a byte-serial datagram's header and segment chain and gives one
// verdict per datagram on its last byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Moves          Payload
//  in_ch    sink       one byte item  data_byte, last_byte, peer_usable
//  out_ch   source     one verdict    accepted, verdict, group_index, payload_bytes
//  cfg      sink       register write reg_index, wdata (always ready)
//
// One byte item is taken per cycle while no last byte waits on the output. An
// item is held in the input register and is checked against the per-datagram
// state as it leaves; on a last byte the verdict is loaded into the output
// register as that byte leaves the input register, and is offered from there.
// Reset clears all per-datagram state and sets group_count to one.
// Only a last byte waits on a full output register; other bytes keep flowing
// while a verdict is still waiting to be taken.
// ----------------------------------------------------------------------------
module datagram_header_segment_validator
    import dhsv_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1400
)
(
    input  logic          clk,
    input  logic          rst_n,
    dhsv_in_if.sink       in_ch,
    dhsv_out_if.source    out_ch,
    dhsv_cfg_if.sink      cfg
);

    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_DATAGRAM);
    localparam logic [POS_W-1:0] MIN_IDX   = POS_W'(MIN_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HDR_BYTES - 1);

    // Configuration registers.
    logic [SESSION_W-1:0] session_reg;
    logic [GCOUNT_W-1:0]  gcount_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 peer_in_reg;

    // Per-datagram state.
    logic [POS_W-1:0]     pos_reg,   pos_next;
    logic                 peer_reg,  peer_next;
    logic [GROUP_W-1:0]   group_reg, group_next;
    verdict_t             err_reg,   err_next;

    // Output register.
    logic                 out_valid_reg;
    logic                 acc_reg;
    verdict_t             verdict_reg, verdict_next;
    logic [2:0]           gidx_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic                 advance;
    logic                 walk;
    logic [2:0]           sess_sel;
    logic [7:0]           sess_byte;
    verdict_t             hdr_fault;
    walk_status_t         wstat;

    // Byte stage moves unless a last byte meets a full output register.
    assign advance     = in_valid_reg && (!last_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;
    assign walk        = (pos_reg >= HDR_POS);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            session_reg <= '0;
            gcount_reg  <= GCOUNT_W'(1);
        end
        else if (cfg.valid) begin
            case (cfg_reg_t'(cfg.reg_index))
                REG_SESSION:     session_reg <= cfg.wdata;
                REG_GROUP_COUNT: gcount_reg  <= cfg.wdata[GCOUNT_W-1:0];
                default:         session_reg <= session_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid) begin
            byte_reg    <= in_ch.data_byte;
            last_reg    <= in_ch.last_byte;
            peer_in_reg <= in_ch.peer_usable;
        end
    end

    // Segment walker for bytes past the main header.
    dhsv_seg_walk #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_seg_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .walk      (walk),
        .clear     (last_reg),
        .data_byte (byte_reg),
        .position  (pos_reg),
        .status    (wstat)
    );

    // Session byte for header offsets four to eleven.
    assign sess_sel  = pos_reg[2:0] + 3'd4;
    assign sess_byte = session_reg[{sess_sel, 3'b000} +: 8];

    // Main header checks and group capture.
    always_comb
    begin
        group_next = group_reg;
        hdr_fault  = V_OK;
        if (pos_reg < POS_W'(4)) begin
            if (byte_reg != magic_byte(pos_reg[1:0]))
                hdr_fault = V_MAGIC;
        end
        else if (pos_reg < POS_W'(12)) begin
            if (byte_reg != sess_byte)
                hdr_fault = V_SESSION;
        end
        else if (pos_reg == POS_W'(12)) begin
            group_next[7:0] = byte_reg;
        end
        else if (pos_reg == HDR_LAST) begin
            group_next[15:8] = byte_reg;
            if (group_next >= GROUP_W'(gcount_reg))
                hdr_fault = V_GROUP;
        end
    end

    // First fault, peer latch, position and verdict.
    always_comb
    begin
        err_next = err_reg;
        if (err_next == V_OK && hdr_fault != V_OK)
            err_next = hdr_fault;
        if (err_next == V_OK && wstat.fault != V_OK)
            err_next = wstat.fault;
        if (err_next == V_OK && last_reg && wstat.busy)
            err_next = V_LENGTH;

        peer_next = (pos_reg == '0) ? peer_in_reg : peer_reg;
        pos_next  = (&pos_reg) ? pos_reg : pos_reg + POS_W'(1);

        if (!peer_next)
            verdict_next = V_PEER;
        else if (pos_reg >= MAX_POS || pos_reg < MIN_IDX)
            verdict_next = V_SIZE;
        else
            verdict_next = err_next;
    end

    // Per-datagram state, cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            peer_reg  <= 1'b0;
            group_reg <= '0;
            err_reg   <= V_OK;
        end
        else if (advance) begin
            if (last_reg) begin
                pos_reg   <= '0;
                peer_reg  <= 1'b0;
                group_reg <= '0;
                err_reg   <= V_OK;
            end
            else begin
                pos_reg   <= pos_next;
                peer_reg  <= peer_next;
                group_reg <= group_next;
                err_reg   <= err_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg) begin
            acc_reg     <= (verdict_next == V_OK);
            verdict_reg <= verdict_next;
            gidx_reg    <= (verdict_next == V_OK) ? group_next[2:0] : 3'd0;
            payload_reg <= (verdict_next == V_OK) ? (pos_reg - HDR_LAST) : '0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.accepted      = acc_reg;
    assign out_ch.verdict       = verdict_reg;
    assign out_ch.group_index   = gidx_reg;
    assign out_ch.payload_bytes = payload_reg;

endmodule
